@@ src/grema_pkg.sv @@
// Shared types and constants of the glitch-rejecting EMA filter.
package grema_pkg;

	// Channel count and field widths, fixed by the port list
	localparam int CHANNELS      = 4;
	localparam int SAMPLE_BITS   = 12;
	localparam int FRACTION_BITS = 16;
	localparam int COUNT_BITS    = 4;
	localparam int WEIGHT_BITS   = FRACTION_BITS + 1;

	// Configuration port widths
	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS  = WEIGHT_BITS;

	typedef logic [SAMPLE_BITS-1:0] sample_t;
	typedef logic [COUNT_BITS-1:0]  count_t;
	typedef logic [WEIGHT_BITS-1:0] weight_t;
	typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;
	typedef logic [CFG_DATA_BITS-1:0]  cfg_data_t;

	// Unity weight: the average takes the sample outright
	localparam weight_t WEIGHT_ONE = weight_t'(1) << FRACTION_BITS;

	// Register indexes
	localparam cfg_index_t REG_REJECT_THRESHOLD = 2'd0;
	localparam cfg_index_t REG_MAX_BAD_IN_ROW   = 2'd1;
	localparam cfg_index_t REG_SMOOTHING_WEIGHT = 2'd2;

	// Register reset values
	localparam sample_t RST_REJECT_THRESHOLD = 12'd175;
	localparam count_t  RST_MAX_BAD_IN_ROW   = 4'd4;
	localparam weight_t RST_SMOOTHING_WEIGHT = 17'd10427;

	// Settings every lane sees; weight is held already saturated to unity
	typedef struct packed {
		sample_t threshold;
		count_t  max_bad;
		weight_t weight;
	} cfg_t;

endpackage

@@ src/glitch_rejecting_ema_filter.sv @@
// Top level of the four-channel glitch-rejecting EMA filter.
//
// Input channel: in_valid / in_stall carries one sample per converter channel
// (sample_ch0..sample_ch3). Output channel: out_valid / out_stall carries the
// four updated averages (filtered_ch0..filtered_ch3), one result per item.
// A transfer happens at a clock edge with valid high and stall low.
// Each channel has its own lane (compare, bad-run counter, one 13x18 multiply
// and add); a shared output register merges the lanes into one result.
// Latency: the result is valid the cycle after the input transfer.
// Throughput: one item per cycle while the receiver does not stall, set by the lane update loop.
// When the receiver stalls, the result holds in the output register and
// in_stall rises, so at most one result waits; no item is lost or repeated.
// Reset (arst_n low) clears all averages and bad-run counts, empties the
// output register and loads the register defaults (threshold 175, run limit 4,
// weight 10427/65536). Configuration writes via cfg_wr_en / cfg_index /
// cfg_data take effect at once and are meant for idle periods; a weight above
// unity is stored as unity and unknown indexes are ignored.
module glitch_rejecting_ema_filter (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  grema_pkg::cfg_index_t  cfg_index,
	input  grema_pkg::cfg_data_t   cfg_data,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  grema_pkg::sample_t     sample_ch0,
	input  grema_pkg::sample_t     sample_ch1,
	input  grema_pkg::sample_t     sample_ch2,
	input  grema_pkg::sample_t     sample_ch3,
	output logic                   out_valid,
	input  logic                   out_stall,
	output grema_pkg::sample_t     filtered_ch0,
	output grema_pkg::sample_t     filtered_ch1,
	output grema_pkg::sample_t     filtered_ch2,
	output grema_pkg::sample_t     filtered_ch3
);

	grema_pkg::cfg_t    cfg_q;
	grema_pkg::sample_t samples  [grema_pkg::CHANNELS];
	grema_pkg::sample_t lane_avg [grema_pkg::CHANNELS];
	grema_pkg::sample_t out_avg  [grema_pkg::CHANNELS];
	logic               full_stalled;
	logic               accept;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.threshold <= grema_pkg::RST_REJECT_THRESHOLD;
			cfg_q.max_bad   <= grema_pkg::RST_MAX_BAD_IN_ROW;
			cfg_q.weight    <= grema_pkg::RST_SMOOTHING_WEIGHT;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				grema_pkg::REG_REJECT_THRESHOLD: begin
					cfg_q.threshold <= cfg_data[grema_pkg::SAMPLE_BITS-1:0];
				end
				grema_pkg::REG_MAX_BAD_IN_ROW: begin
					cfg_q.max_bad <= cfg_data[grema_pkg::COUNT_BITS-1:0];
				end
				grema_pkg::REG_SMOOTHING_WEIGHT: begin
					cfg_q.weight <= (cfg_data > grema_pkg::WEIGHT_ONE) ?
						grema_pkg::WEIGHT_ONE : cfg_data[grema_pkg::WEIGHT_BITS-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Input transfer whenever the output register is free or being emptied
	assign in_stall = full_stalled;
	assign accept   = in_valid & ~full_stalled;

	assign samples[0] = sample_ch0;
	assign samples[1] = sample_ch1;
	assign samples[2] = sample_ch2;
	assign samples[3] = sample_ch3;

	// One lane per channel
	for (genvar i = 0; i < grema_pkg::CHANNELS; i++) begin : g_lane
		grema_lane u_lane (
			.clk      (clk),
			.arst_n   (arst_n),
			.accept   (accept),
			.cfg      (cfg_q),
			.sample   (samples[i]),
			.avg_next (lane_avg[i])
		);
	end

	// Merge lane results into the output register
	grema_out_stage u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (accept),
		.lane_avg     (lane_avg),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.out_avg      (out_avg),
		.full_stalled (full_stalled)
	);

	assign filtered_ch0 = out_avg[0];
	assign filtered_ch1 = out_avg[1];
	assign filtered_ch2 = out_avg[2];
	assign filtered_ch3 = out_avg[3];

endmodule

@@ src/grema_lane.sv @@
// One channel lane: glitch check, bad-run counter and EMA update.
module grema_lane (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  grema_pkg::cfg_t  cfg,
	input  grema_pkg::sample_t sample,
	output grema_pkg::sample_t avg_next
);

	localparam int SB = grema_pkg::SAMPLE_BITS;
	localparam int WB = grema_pkg::WEIGHT_BITS;
	localparam int FB = grema_pkg::FRACTION_BITS;

	grema_pkg::sample_t avg_q;
	grema_pkg::count_t  cnt_q;

	logic signed [SB:0]      diff;
	grema_pkg::sample_t      delta_abs;
	logic signed [SB+WB+1:0] prod;
	grema_pkg::sample_t      blend;
	grema_pkg::count_t       cnt_inc;
	grema_pkg::count_t       cnt_next;
	logic                    reject;
	logic                    snap;

	// avg' = avg + floor((sample - avg) * a / 2^F), equal to the two-term blend
	always_comb begin
		diff      = $signed({1'b0, sample}) - $signed({1'b0, avg_q});
		delta_abs = (sample >= avg_q) ? (sample - avg_q) : (avg_q - sample);
		prod      = diff * $signed({1'b0, cfg.weight});
		blend     = avg_q + prod[FB+SB-1:FB];
		cnt_inc   = cnt_q + grema_pkg::count_t'(1);
		reject    = delta_abs > cfg.threshold;
		snap      = cnt_inc >= cfg.max_bad;
	end

	// Next state of the lane
	always_comb begin
		if (!reject) begin
			avg_next = blend;
			cnt_next = '0;
		end else if (snap) begin
			avg_next = sample;
			cnt_next = '0;
		end else begin
			avg_next = avg_q;
			cnt_next = cnt_inc;
		end
	end

	// Lane state advances on each input transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avg_q <= '0;
			cnt_q <= '0;
		end else if (accept) begin
			avg_q <= avg_next;
			cnt_q <= cnt_next;
		end
	end

endmodule

@@ src/grema_out_stage.sv @@
// Merging output register: collects all lane results into one output transfer.
module grema_out_stage (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  grema_pkg::sample_t lane_avg [grema_pkg::CHANNELS],
	input  logic               out_stall,
	output logic               out_valid,
	output grema_pkg::sample_t out_avg [grema_pkg::CHANNELS],
	output logic               full_stalled
);

	logic               valid_q;
	grema_pkg::sample_t data_q [grema_pkg::CHANNELS];

	// Valid flag: set by a load, cleared once the result is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	// Payload register
	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= lane_avg;
		end
	end

	assign out_valid    = valid_q;
	assign out_avg      = data_q;
	assign full_stalled = valid_q & out_stall;

endmodule

@@ src/grema_checker.sv @@
// Port-level checks of the filter's handshake behavior, bound to the top level.
module grema_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input grema_pkg::sample_t filtered_ch0,
	input grema_pkg::sample_t filtered_ch1,
	input grema_pkg::sample_t filtered_ch2,
	input grema_pkg::sample_t filtered_ch3
);

	// Every input transfer yields a result in the next cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> out_valid)
		else $error("no result after input transfer");

	// A waiting, stalled result blocks the input side
	a_stall_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |-> in_stall)
		else $error("input taken while result is stalled");

	// An empty output register never stalls the input
	a_no_stall_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty output");

	// A stalled result stays put
	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(filtered_ch0)
			&& $stable(filtered_ch1) && $stable(filtered_ch2) && $stable(filtered_ch3))
		else $error("stalled result changed");

endmodule

bind glitch_rejecting_ema_filter grema_checker u_grema_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.filtered_ch0 (filtered_ch0),
	.filtered_ch1 (filtered_ch1),
	.filtered_ch2 (filtered_ch2),
	.filtered_ch3 (filtered_ch3)
);

@@ tb/testbench.sv @@
// Self-checking testbench for the four-channel glitch-rejecting EMA filter.
module testbench;

	typedef grema_pkg::sample_t [grema_pkg::CHANNELS-1:0] lanes_t;

	// Index past the register list; writes to it must be ignored
	localparam grema_pkg::cfg_index_t REG_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 300000;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_ITEMS = 62;

	// Tracks the expected averages and compares each filtered result
	class average_tracker;
		grema_pkg::sample_t threshold;
		grema_pkg::count_t  max_bad;
		grema_pkg::weight_t weight;
		grema_pkg::sample_t avg [grema_pkg::CHANNELS];
		grema_pkg::count_t  bad_run [grema_pkg::CHANNELS];
		lanes_t  pending_averages [$];
		int      errors;
		int      results_seen;

		function new();
			threshold = grema_pkg::RST_REJECT_THRESHOLD;
			max_bad   = grema_pkg::RST_MAX_BAD_IN_ROW;
			weight    = grema_pkg::RST_SMOOTHING_WEIGHT;
			for (int ch = 0; ch < grema_pkg::CHANNELS; ch++) begin
				avg[ch]     = '0;
				bad_run[ch] = '0;
			end
			errors       = 0;
			results_seen = 0;
		endfunction

		function void set_reg(grema_pkg::cfg_index_t idx, grema_pkg::cfg_data_t v);
			case (idx)
				grema_pkg::REG_REJECT_THRESHOLD:
					threshold = v[grema_pkg::SAMPLE_BITS-1:0];
				grema_pkg::REG_MAX_BAD_IN_ROW:
					max_bad   = v[grema_pkg::COUNT_BITS-1:0];
				grema_pkg::REG_SMOOTHING_WEIGHT:
					weight    = v[grema_pkg::WEIGHT_BITS-1:0];
				default: ;
			endcase
		endfunction

		// One lane: accept and blend, or count the outlier and snap at the limit
		function grema_pkg::sample_t advance_lane(int ch, grema_pkg::sample_t smp);
			grema_pkg::sample_t delta_abs;
			grema_pkg::count_t  nxt;
			grema_pkg::weight_t a;
			logic [31:0]        acc;
			delta_abs = (smp >= avg[ch]) ? smp - avg[ch] : avg[ch] - smp;
			if (delta_abs > threshold) begin
				nxt = bad_run[ch] + 1'b1;
				if (nxt >= max_bad) begin
					bad_run[ch] = '0;
					avg[ch]     = smp;
				end else begin
					bad_run[ch] = nxt;
				end
			end else begin
				a = (weight > grema_pkg::WEIGHT_ONE) ? grema_pkg::WEIGHT_ONE : weight;
				acc = 32'(smp) * 32'(a) + 32'(avg[ch]) * 32'(grema_pkg::WEIGHT_ONE - a);
				bad_run[ch] = '0;
				avg[ch]     = acc[grema_pkg::FRACTION_BITS +: grema_pkg::SAMPLE_BITS];
			end
			return avg[ch];
		endfunction

		function void note_input(lanes_t s);
			lanes_t want;
			for (int ch = 0; ch < grema_pkg::CHANNELS; ch++)
				want[ch] = advance_lane(ch, s[ch]);
			pending_averages.push_back(want);
		endfunction

		task report(string msg);
			errors++;
			$display("ERROR: %s", msg);
		endtask

		task check_result(lanes_t got);
			lanes_t want;
			int     ch;
			results_seen++;
			if (pending_averages.size() == 0) begin
				report($sformatf("result %0d arrived with nothing outstanding", results_seen));
			end else begin
				want = pending_averages.pop_front();
				for (ch = 0; ch < grema_pkg::CHANNELS; ch++) begin
					if (got[ch] !== want[ch])
						report($sformatf("result %0d filtered_ch%0d got %0d want %0d",
							results_seen, ch, got[ch], want[ch]));
				end
			end
		endtask
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_wr_en;
	grema_pkg::cfg_index_t cfg_index;
	grema_pkg::cfg_data_t  cfg_data;
	logic                  in_valid;
	logic                  in_stall;
	lanes_t                smp;
	logic                  out_valid;
	logic                  out_stall;
	grema_pkg::sample_t    filt0, filt1, filt2, filt3;

	average_tracker sb = new();

	int  sent;
	int  settings_used;
	int  cycles;
	bit  in_calm;
	bit  out_calm;
	int  cur_thr;
	int  level [grema_pkg::CHANNELS];
	int  burst_left [grema_pkg::CHANNELS];

	glitch_rejecting_ema_filter dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.sample_ch0   (smp[0]),
		.sample_ch1   (smp[1]),
		.sample_ch2   (smp[2]),
		.sample_ch3   (smp[3]),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.filtered_ch0 (filt0),
		.filtered_ch1 (filt1),
		.filtered_ch2 (filt2),
		.filtered_ch3 (filt3)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watch both channels; a transfer predicts or checks
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				sb.note_input(smp);
			if (out_valid && !out_stall)
				sb.check_result({filt3, filt2, filt1, filt0});
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Receiver: random stall before each result, or none in calm stretches
	initial begin
		int n;
		forever begin
			n = out_calm ? 0 : $urandom_range(0, 13);
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	function automatic lanes_t lanes(int c0, int c1, int c2, int c3);
		return {grema_pkg::sample_t'(c3), grema_pkg::sample_t'(c2),
			grema_pkg::sample_t'(c1), grema_pkg::sample_t'(c0)};
	endfunction

	// Signal level per lane with noise around the threshold, glitch bursts and steps
	function automatic lanes_t next_sample_set();
		lanes_t s;
		int     span;
		int     v;
		span = cur_thr + cur_thr / 3 + 3;
		if (span > 4095)
			span = 4095;
		for (int ch = 0; ch < grema_pkg::CHANNELS; ch++) begin
			if ($urandom_range(0, 49) == 0)
				level[ch] = $urandom_range(0, 4095);
			if ($urandom_range(0, 11) == 0) begin
				v = $urandom_range(0, 4095);
			end else if (burst_left[ch] > 0) begin
				burst_left[ch]--;
				v = $urandom_range(0, 4095);
			end else if ($urandom_range(0, 15) == 0) begin
				burst_left[ch] = $urandom_range(0, 16);
				v = $urandom_range(0, 4095);
			end else begin
				v = level[ch] + $urandom_range(0, 2 * span) - span;
			end
			if (v < 0)
				v = 0;
			if (v > 4095)
				v = 4095;
			s[ch] = grema_pkg::sample_t'(v);
		end
		return s;
	endfunction

	task automatic send_item(input lanes_t s);
		int gap;
		gap = in_calm ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		smp      <= s;
		do @(posedge clk); while (in_stall);
		sent++;
	endtask

	// Hold the sender until every result is back, then let the block settle
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (sb.results_seen < sent) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic put_reg(input grema_pkg::cfg_index_t idx, input grema_pkg::cfg_data_t v);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		@(posedge clk);
		sb.set_reg(idx, v);
	endtask

	task automatic apply_settings(input grema_pkg::cfg_data_t thr,
			input grema_pkg::cfg_data_t mb, input grema_pkg::cfg_data_t wt);
		put_reg(grema_pkg::REG_REJECT_THRESHOLD, thr);
		put_reg(grema_pkg::REG_MAX_BAD_IN_ROW, mb);
		put_reg(grema_pkg::REG_SMOOTHING_WEIGHT, wt);
		if ($urandom_range(0, 2) == 0)
			put_reg(REG_UNUSED, grema_pkg::cfg_data_t'($urandom));
		cfg_wr_en <= 1'b0;
		cur_thr = thr[grema_pkg::SAMPLE_BITS-1:0];
		settings_used++;
	endtask

	initial begin
		grema_pkg::cfg_data_t thr;
		grema_pkg::cfg_data_t mb;
		grema_pkg::cfg_data_t wt;
		arst_n    <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_index <= grema_pkg::REG_REJECT_THRESHOLD;
		cfg_data  <= '0;
		in_valid  <= 1'b0;
		smp       <= '0;
		cycles    <= 0;
		sent          = 0;
		settings_used = 1;
		in_calm       = 0;
		out_calm      = 0;
		cur_thr       = grema_pkg::RST_REJECT_THRESHOLD;
		for (int ch = 0; ch < grema_pkg::CHANNELS; ch++) begin
			level[ch]      = $urandom_range(0, 4095);
			burst_left[ch] = 0;
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Start-up at defaults: far lanes snap after the run limit, near lanes blend
		repeat (4) send_item(lanes(4095, 2048, 0, 1));
		send_item(lanes(3920, 2223, 175, 176));
		send_item(lanes(0, 4095, 4095, 0));
		send_item(lanes(4095, 2048, 0, 0));

		// Weight above unity saturates, widest threshold, longest run limit
		wait_idle();
		put_reg(REG_UNUSED, 17'h1FFFF);
		apply_settings(17'h00FFF, 17'h0000F, 17'h1FFFF);
		send_item(lanes(0, 4095, 12'hAAA, 12'h555));
		send_item(lanes(4095, 0, 12'h555, 12'hAAA));
		send_item(lanes(1, 2, 4094, 4093));

		// Zero threshold and zero run limit, upper data bits set; weight zero
		wait_idle();
		apply_settings(17'h1F000, 17'h1FFF0, 17'h00000);
		send_item(lanes(100, 200, 300, 400));
		send_item(lanes(100, 200, 300, 400));
		send_item(lanes(101, 199, 300, 4095));

		// Run limit of one with unity weight, then tiny and near-unity weights
		wait_idle();
		apply_settings(17'h00FFF, 17'h00001, grema_pkg::cfg_data_t'(grema_pkg::WEIGHT_ONE));
		send_item(lanes(4095, 0, 2000, 3000));
		send_item(lanes(0, 4095, 2100, 2900));
		wait_idle();
		apply_settings(17'h00800, 17'h00002, 17'h00001);
		send_item(lanes(4095, 4095, 0, 2047));
		wait_idle();
		apply_settings(17'h00800, 17'h00002, 17'h0FFFF);
		send_item(lanes(4095, 4095, 0, 2047));

		// Random phases, each under freshly drawn settings
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			wait_idle();
			case ($urandom_range(0, 3))
				0: thr = grema_pkg::cfg_data_t'($urandom_range(0, 32));
				1: thr = grema_pkg::cfg_data_t'($urandom_range(100, 400));
				2: thr = grema_pkg::cfg_data_t'($urandom_range(0, 4095));
				default: thr = 17'h00FFF;
			endcase
			thr[grema_pkg::WEIGHT_BITS-1:grema_pkg::SAMPLE_BITS] =
				(grema_pkg::WEIGHT_BITS - grema_pkg::SAMPLE_BITS)'($urandom);
			mb = grema_pkg::cfg_data_t'($urandom);
			case ($urandom_range(0, 4))
				0: wt = '0;
				1: wt = grema_pkg::cfg_data_t'(grema_pkg::WEIGHT_ONE);
				2: wt = grema_pkg::cfg_data_t'($urandom_range(65537, 131071));
				default: wt = grema_pkg::cfg_data_t'($urandom_range(1, 65535));
			endcase
			apply_settings(thr, mb, wt);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (i % 20 == 0) begin
					in_calm  = ($urandom_range(0, 3) == 0);
					out_calm = ($urandom_range(0, 3) == 0);
				end
				send_item(next_sample_set());
			end
		end

		in_calm  = 0;
		out_calm = 0;
		wait_idle();
		repeat (5) @(posedge clk);
		$display("Covered %0d sample sets under %0d filter settings", sent, settings_used);
		$display("%0d filtered results compared lane by lane", sb.results_seen);
		if (sb.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
